[hw/rtl/two_nearest_prototype_search_defines.svh]
// ----------------------------------------------------------------------------
// two_nearest_prototype_search_defines
// assertion macros shared by the checker of the two-nearest search block
// ----------------------------------------------------------------------------
`ifndef TWO_NEAREST_PROTOTYPE_SEARCH_DEFINES_SVH
`define TWO_NEAREST_PROTOTYPE_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define TNPS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tnps check failed");

// next-cycle implication, sampled on clock, off during reset
`define TNPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tnps check failed");

`endif

[hw/rtl/tnps_pkg.sv]
// ----------------------------------------------------------------------------
// tnps_pkg
// types, codes and the control program of the two-nearest prototype search
// ----------------------------------------------------------------------------
package tnps_pkg;

   localparam int NEURONS_DEF = 64;
   localparam int DIM_DEF     = 16;

   localparam int OP_W     = 2;
   localparam int IDX_W    = 6;
   localparam int ELEM_W   = 4;
   localparam int VAL_W    = 16;
   localparam int DIMS_W   = 5;
   localparam int DIST_W   = 36;
   localparam int PROD_W   = 32;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 56;
   localparam int PC_W     = 4;

   localparam logic [DIMS_W-1:0] DIMS_RESET = 5'd16;
   localparam logic [DIST_W-1:0] DIST_MAX   = '1;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_FLAG  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [PC_W-1:0] ST_INIT  = 4'd1;
   localparam logic [PC_W-1:0] ST_TOP   = 4'd2;
   localparam logic [PC_W-1:0] ST_CHECK = 4'd3;
   localparam logic [PC_W-1:0] ST_MAC   = 4'd4;
   localparam logic [PC_W-1:0] ST_DRAIN = 4'd5;
   localparam logic [PC_W-1:0] ST_CMP   = 4'd6;
   localparam logic [PC_W-1:0] ST_NEXT  = 4'd7;
   localparam logic [PC_W-1:0] ST_RESP  = 4'd8;
   localparam logic [PC_W-1:0] ST_RET   = 4'd9;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_NO_START,
      C_NEUR_DONE,
      C_NOT_ELIG,
      C_MORE,
      C_BUSY,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic            ready;
      logic            clr_scan;
      logic            vec_start;
      logic            issue;
      logic            cmp;
      logic            next_neuron;
      logic            respond;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctl_type;

   typedef struct packed {
      logic neur_done;
      logic not_elig;
      logic more;
      logic pipe_busy;
   } dp_status_type;

   typedef struct packed {
      logic          start;
      logic          out_busy;
      dp_status_type dp;
   } status_type;

   typedef struct packed {
      logic [DIST_W-1:0] best_distance;
      logic              second_found;
      logic [IDX_W-1:0]  second_index;
      logic              best_found;
      logic [IDX_W-1:0]  best_index;
   } result_type;

   function automatic ctl_type ucode_rom(input logic [PC_W-1:0] pc);
      ctl_type w;
      w = '0;
      w.cond   = C_ALWAYS;
      w.target = ST_IDLE;
      case (pc)
         ST_IDLE: begin
            w.ready  = 1'b1;
            w.cond   = C_NO_START;
            w.target = ST_IDLE;
         end
         ST_INIT: begin
            w.clr_scan = 1'b1;
            w.target   = ST_TOP;
         end
         ST_TOP: begin
            w.cond   = C_NEUR_DONE;
            w.target = ST_RESP;
         end
         ST_CHECK: begin
            w.vec_start = 1'b1;
            w.cond      = C_NOT_ELIG;
            w.target    = ST_NEXT;
         end
         ST_MAC: begin
            w.issue  = 1'b1;
            w.cond   = C_MORE;
            w.target = ST_MAC;
         end
         ST_DRAIN: begin
            w.cond   = C_BUSY;
            w.target = ST_DRAIN;
         end
         ST_CMP: begin
            w.cmp    = 1'b1;
            w.target = ST_NEXT;
         end
         ST_NEXT: begin
            w.next_neuron = 1'b1;
            w.target      = ST_TOP;
         end
         ST_RESP: begin
            w.respond = 1'b1;
            w.cond    = C_OUT_BUSY;
            w.target  = ST_RESP;
         end
         ST_RET: begin
            w.target = ST_IDLE;
         end
         default: begin
            w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[hw/rtl/tnps_sequencer.sv]
// ----------------------------------------------------------------------------
// tnps_sequencer
// step counter over the control program, with conditional jumps
// ----------------------------------------------------------------------------
module tnps_sequencer
   import tnps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctl_type    ctl
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            take;

   assign ctl = ucode_rom(pc_ff);

   always_comb begin
      case (ctl.cond)
         C_ALWAYS:    take = 1'b1;
         C_NO_START:  take = !status.start;
         C_NEUR_DONE: take = status.dp.neur_done;
         C_NOT_ELIG:  take = status.dp.not_elig;
         C_MORE:      take = status.dp.more;
         C_BUSY:      take = status.dp.pipe_busy;
         C_OUT_BUSY:  take = status.out_busy;
         default:     take = 1'b1;
      endcase
      pc_in = take ? ctl.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[hw/rtl/tnps_datapath.sv]
// ----------------------------------------------------------------------------
// tnps_datapath
// prototype and query memories, eligible flags, pipelined squared-distance
// accumulator and nearest / second-nearest tracking
// ----------------------------------------------------------------------------
module tnps_datapath
   import tnps_pkg::*;
#(
   parameter int NEURONS = NEURONS_DEF,
   parameter int DIM     = DIM_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl,
   input  logic                accept,
   input  logic [OP_W-1:0]     operation,
   input  logic [IDX_W-1:0]    neuron_index,
   input  logic [ELEM_W-1:0]   element_index,
   input  logic [VAL_W-1:0]    value,
   input  logic                eligible,
   input  logic [DIMS_W-1:0]   dims_in_use,
   output dp_status_type       dp_status,
   output result_type          result
);

   localparam int NW = $clog2(NEURONS);
   localparam int CW = $clog2(NEURONS + 1);
   localparam int AW = $clog2(NEURONS * DIM);
   localparam int DW = $clog2(DIM + 1);
   localparam int QW = (DIM > 1) ? $clog2(DIM) : 1;

   logic [VAL_W-1:0] proto_mem [NEURONS*DIM];
   logic [VAL_W-1:0] query_mem [DIM];

   logic [NEURONS-1:0] elig_ff;
   logic [CW-1:0]      n_ff,    n_in;
   logic [AW:0]        base_ff, base_in;
   logic [DW-1:0]      j_ff,    j_in;
   logic [DW-1:0]      dims_eff;

   logic               v1_ff, v2_ff;
   logic [VAL_W-1:0]   p_rd_ff, q_rd_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DIST_W-1:0]  acc_ff,  acc_in;

   logic               bf_ff, bf_in, sf_ff, sf_in;
   logic [NW-1:0]      bi_ff, bi_in, si_ff, si_in;
   logic [DIST_W-1:0]  bd_ff, bd_in, sd_ff, sd_in;

   logic               wr_proto, wr_flag, wr_query, issue_live;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic signed [VAL_W:0]     diff;
   logic signed [2*VAL_W+1:0] square;
   logic [DIST_W:0]           sum;

   assign dims_eff = (int'(dims_in_use) > DIM) ? DW'(DIM) : DW'(dims_in_use);

   assign wr_proto = accept && (operation == OP_WRITE) && (int'(neuron_index) < NEURONS)
                     && (int'(element_index) < DIM);
   assign wr_flag  = accept && (operation == OP_FLAG) && (int'(neuron_index) < NEURONS);
   assign wr_query = accept && (operation == OP_QUERY) && (int'(element_index) < DIM);
   assign wr_addr  = AW'(int'(neuron_index) * DIM + int'(element_index));

   assign issue_live = ctl.issue && (j_ff < dims_eff);
   assign rd_addr    = AW'(base_ff + (AW+1)'(j_ff));

   always_ff @(posedge clock) begin
      if (wr_proto) begin
         proto_mem[wr_addr] <= value;
      end
      if (wr_query) begin
         query_mem[QW'(element_index)] <= value;
      end
      if (issue_live) begin
         p_rd_ff <= proto_mem[rd_addr];
         q_rd_ff <= query_mem[QW'(j_ff)];
      end
   end

   always_comb begin
      diff    = $signed({q_rd_ff[VAL_W-1], q_rd_ff}) - $signed({p_rd_ff[VAL_W-1], p_rd_ff});
      square  = diff * diff;
      prod_in = square[PROD_W-1:0];
   end

   always_comb begin
      sum = {1'b0, acc_ff} + (DIST_W+1)'(prod_ff);
      if (ctl.vec_start) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
      end else begin
         acc_in = acc_ff;
      end
   end

   always_comb begin
      n_in    = n_ff;
      base_in = base_ff;
      if (ctl.clr_scan) begin
         n_in    = '0;
         base_in = '0;
      end else if (ctl.next_neuron) begin
         n_in    = n_ff + 1'b1;
         base_in = base_ff + (AW+1)'(DIM);
      end
      j_in = j_ff;
      if (ctl.vec_start) begin
         j_in = '0;
      end else if (issue_live) begin
         j_in = j_ff + 1'b1;
      end
   end

   always_comb begin
      bf_in = bf_ff;
      sf_in = sf_ff;
      bi_in = bi_ff;
      si_in = si_ff;
      bd_in = bd_ff;
      sd_in = sd_ff;
      if (ctl.clr_scan) begin
         bf_in = 1'b0;
         sf_in = 1'b0;
         bi_in = '0;
         si_in = '0;
         bd_in = '0;
         sd_in = '0;
      end else if (ctl.cmp) begin
         if (!bf_ff || (acc_ff < bd_ff)) begin
            if (bf_ff) begin
               sf_in = 1'b1;
               si_in = bi_ff;
               sd_in = bd_ff;
            end
            bf_in = 1'b1;
            bi_in = NW'(n_ff);
            bd_in = acc_ff;
         end else if (!sf_ff || (acc_ff < sd_ff)) begin
            sf_in = 1'b1;
            si_in = NW'(n_ff);
            sd_in = acc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elig_ff <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         n_ff    <= '0;
         base_ff <= '0;
         j_ff    <= '0;
         bf_ff   <= 1'b0;
         sf_ff   <= 1'b0;
      end else begin
         if (wr_flag) begin
            elig_ff[NW'(neuron_index)] <= eligible;
         end
         v1_ff   <= issue_live;
         v2_ff   <= v1_ff;
         n_ff    <= n_in;
         base_ff <= base_in;
         j_ff    <= j_in;
         bf_ff   <= bf_in;
         sf_ff   <= sf_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      bi_ff   <= bi_in;
      si_ff   <= si_in;
      bd_ff   <= bd_in;
      sd_ff   <= sd_in;
   end

   assign dp_status.neur_done = (n_ff == CW'(NEURONS));
   assign dp_status.not_elig  = !elig_ff[NW'(n_ff)];
   assign dp_status.more      = issue_live && (({1'b0, j_ff} + 1'b1) < {1'b0, dims_eff});
   assign dp_status.pipe_busy = v1_ff || v2_ff;

   assign result.best_index    = IDX_W'(bi_ff);
   assign result.best_found    = bf_ff;
   assign result.second_index  = IDX_W'(si_ff);
   assign result.second_found  = sf_ff;
   assign result.best_distance = bd_ff;

endmodule

[hw/rtl/two_nearest_prototype_search.sv]
// ----------------------------------------------------------------------------
// two_nearest_prototype_search
// nearest and second-nearest eligible prototype by squared euclidean distance
//
//   channel  dir  handshake               payload
//   csr      in   csr_valid / csr_ready   csr_data: dims_in_use
//   req      in   req_tvalid / req_tready tdata, tuser, tlast
//   rsp      out  rsp_tvalid / rsp_tready tdata
//
// write, flag and plain query beats are accepted only while the block is idle
// a query beat with tlast starts a scan, which runs on the single
// multiply-accumulate and the one prototype read port
// reset clears the eligible flags and sets dims_in_use to 16, no clearing pass
// a result waits in the output register while new beats are accepted; the
// next scan holds its result until the previous one is taken
// ----------------------------------------------------------------------------
module two_nearest_prototype_search
   import tnps_pkg::*;
#(
   parameter int NEURONS = NEURONS_DEF,
   parameter int DIM     = DIM_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [DIMS_W-1:0] csr_data,
   input  logic              req_tvalid,
   output logic              req_tready,
   // neuron_index, element_index, value, eligible, zero fill
   input  logic [REQ_W-1:0]  req_tdata,
   // operation
   input  logic [OP_W-1:0]   req_tuser,
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // best_index, best_found, second_index, second_found, best_distance, zero fill
   output logic [RSP_W-1:0]  rsp_tdata
);

   logic [DIMS_W-1:0] dims_ff;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;
   logic              accept, load;
   ctl_type           ctl;
   status_type        status;
   dp_status_type     dp_status;
   result_type        result;

   assign csr_ready  = 1'b1;
   assign req_tready = ctl.ready;
   assign accept     = req_tvalid && req_tready;

   assign status.start    = accept && (req_tuser == OP_QUERY) && req_tlast;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;
   assign status.dp       = dp_status;
   assign load            = ctl.respond && !status.out_busy;

   tnps_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   tnps_datapath #(
      .NEURONS (NEURONS),
      .DIM     (DIM)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .accept        (accept),
      .operation     (req_tuser),
      .neuron_index  (req_tdata[5:0]),
      .element_index (req_tdata[9:6]),
      .value         (req_tdata[25:10]),
      .eligible      (req_tdata[26]),
      .dims_in_use   (dims_ff),
      .dp_status     (dp_status),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff      <= DIMS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            dims_ff <= csr_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= RSP_W'(result);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hw/rtl/tnps_checker.sv]
// ----------------------------------------------------------------------------
// tnps_checker
// port-level checks of the two-nearest prototype search, bound to the top
// ----------------------------------------------------------------------------
`include "two_nearest_prototype_search_defines.svh"

module tnps_checker
   import tnps_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [OP_W-1:0]   req_tuser,
   input logic              req_tlast,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_W-1:0]  rsp_tdata
);

   // a waiting result holds
   `TNPS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a last query beat starts a scan, so the request side closes
   `TNPS_ASSERT_NEXT(a_scan_closes,
      req_tvalid && req_tready && req_tlast && (req_tuser == OP_QUERY), !req_tready)

   // second place needs a first place
   `TNPS_ASSERT_NOW(a_second_needs_best, rsp_tvalid && rsp_tdata[13], rsp_tdata[6])

   // nothing found reads as all zero
   `TNPS_ASSERT_NOW(a_empty_zero, rsp_tvalid && !rsp_tdata[6], rsp_tdata == '0)

   // the two winners are different prototypes
   `TNPS_ASSERT_NOW(a_distinct, rsp_tvalid && rsp_tdata[13], rsp_tdata[12:7] != rsp_tdata[5:0])

endmodule

bind two_nearest_prototype_search tnps_checker u_checker (.*);
